### rtl/core/igc_pkg.sv
// ----------------------------------------------------------------------------
// igc_pkg: iteration gradient colorizer package
// Palette stops, per-segment widths and reciprocals, fixed-point constants.
// ----------------------------------------------------------------------------
package igc_pkg;

  // Q0.16 fixed point, 1.0 needs 17 bits
  localparam int unsigned FracW    = 16;
  localparam logic [16:0] OneQ16   = 17'h10000;
  localparam logic [25:0] HalfQ16  = 26'h0008000;

  // palette layout
  localparam int unsigned StopCnt  = 18;
  localparam int unsigned SegCnt   = StopCnt - 1;
  localparam int unsigned SegW     = 5;
  localparam int unsigned DiffW    = 13;   // widest segment is 6554
  localparam int unsigned SegRcpW  = 23;   // floor(2^32 / width), width >= 655

  // limit reciprocal: floor((2^24 - 1) / limit)
  localparam int unsigned LimRcpW  = 24;

  // config register indexes
  localparam logic RegIterLimit = 1'b0;

  // stop positions, Q0.16 rounded
  localparam logic [16:0] STOP_POS [StopCnt] = '{
    17'd0,     17'd3932,  17'd7864,  17'd7864,  17'd10486, 17'd11141,
    17'd13107, 17'd13763, 17'd16384, 17'd19661, 17'd26214, 17'd32768,
    17'd39322, 17'd45875, 17'd52429, 17'd57672, 17'd61604, 17'd65536
  };

  localparam logic [7:0] STOP_R [StopCnt] = '{
    8'd30,  8'd20,  8'd255, 8'd30,  8'd255, 8'd255, 8'd20,  8'd255, 8'd255,
    8'd40,  8'd50,  8'd120, 8'd220, 8'd255, 8'd255, 8'd255, 8'd255, 8'd180
  };

  localparam logic [7:0] STOP_G [StopCnt] = '{
    8'd30,  8'd30,  8'd255, 8'd80,  8'd220, 8'd160, 8'd140, 8'd220, 8'd160,
    8'd200, 8'd220, 8'd230, 8'd240, 8'd220, 8'd160, 8'd90,  8'd70,  8'd60
  };

  localparam logic [7:0] STOP_B [StopCnt] = '{
    8'd30,  8'd90,  8'd255, 8'd170, 8'd40,  8'd40,  8'd220, 8'd40,  8'd40,
    8'd180, 8'd120, 8'd80,  8'd60,  8'd40,  8'd40,  8'd70,  8'd150, 8'd255
  };

  // segment widths (right stop minus left stop); the duplicate stop gives zero
  localparam logic [DiffW-1:0] SEG_WIDTH [SegCnt] = '{
    13'd3932, 13'd3932, 13'd0,    13'd2622, 13'd655,  13'd1966,
    13'd656,  13'd2621, 13'd3277, 13'd6553, 13'd6554, 13'd6554,
    13'd6553, 13'd6554, 13'd5243, 13'd3932, 13'd3932
  };

  localparam longint unsigned Two32 = 64'd4294967296;

  // floor(2^32 / width); zero-width segment gets zero
  localparam logic [SegRcpW-1:0] SEG_RECIP [SegCnt] = '{
    SegRcpW'(Two32 / 64'd3932), SegRcpW'(Two32 / 64'd3932), '0,
    SegRcpW'(Two32 / 64'd2622), SegRcpW'(Two32 / 64'd655),
    SegRcpW'(Two32 / 64'd1966), SegRcpW'(Two32 / 64'd656),
    SegRcpW'(Two32 / 64'd2621), SegRcpW'(Two32 / 64'd3277),
    SegRcpW'(Two32 / 64'd6553), SegRcpW'(Two32 / 64'd6554),
    SegRcpW'(Two32 / 64'd6554), SegRcpW'(Two32 / 64'd6553),
    SegRcpW'(Two32 / 64'd6554), SegRcpW'(Two32 / 64'd5243),
    SegRcpW'(Two32 / 64'd3932), SegRcpW'(Two32 / 64'd3932)
  };

endpackage

### rtl/core/iteration_gradient_colorizer.sv
// ----------------------------------------------------------------------------
// iteration_gradient_colorizer: iteration count to RGB gradient map
// Six-stage pipeline: limit reciprocal multiply, quotient fix-up, segment
// search, segment reciprocal multiply, fraction fix-up, channel blend.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register is full and stalled.
// Reset: valid bits cleared, iteration_limit set to 255.
// ----------------------------------------------------------------------------
module iteration_gradient_colorizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  iteration_count_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  localparam int unsigned RcpW  = igc_pkg::LimRcpW;
  localparam int unsigned SegW  = igc_pkg::SegW;
  localparam int unsigned DiffW = igc_pkg::DiffW;
  localparam int unsigned FracW = igc_pkg::FracW;
  localparam logic [RcpW-1:0] RcpReset = RcpW'((2**24 - 1) / 255);

  // --------------------------------------------------------------------------
  // limit reciprocal table, built at elaboration
  // --------------------------------------------------------------------------
  logic [RcpW-1:0] recip_tbl [256];

  for (genvar g = 0; g < 256; g++) begin : gen_recip
    localparam int unsigned RcpVal = (g == 0) ? 0 : (2**24 - 1) / ((g == 0) ? 1 : g);
    assign recip_tbl[g] = RcpW'(RcpVal);
  end

  // --------------------------------------------------------------------------
  // configuration register and its reciprocal
  // --------------------------------------------------------------------------
  logic [7:0]      limit_q;
  logic [RcpW-1:0] recip_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == igc_pkg::RegIterLimit);
  assign prdata = (paddr[2] == igc_pkg::RegIterLimit) ? {24'h0, limit_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 8'd255;
      recip_q <= RcpReset;
    end else if (cfg_wr) begin
      limit_q <= pwdata[7:0];
      recip_q <= recip_tbl[pwdata[7:0]];
    end
  end

  // --------------------------------------------------------------------------
  // pipeline advance: hold everything while the output is full and stalled
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: black test, approximate t = count * recip >> 8 (may be one low)
  // --------------------------------------------------------------------------
  logic [31:0]      prod1;
  logic             black1_q;
  logic [7:0]       cnt1_q;
  logic [FracW-1:0] qa1_q;

  assign prod1 = 32'(iteration_count_i) * 32'(recip_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      black1_q <= (iteration_count_i >= limit_q);
      cnt1_q   <= iteration_count_i;
      qa1_q    <= prod1[23:8];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: remainder check, exact t = floor(count * 65536 / limit)
  // --------------------------------------------------------------------------
  logic [23:0]      qmul2;
  logic [23:0]      rem2;
  logic [FracW-1:0] t2_d;
  logic             black2_q;
  logic [FracW-1:0] t2_q;

  assign qmul2 = 24'(qa1_q) * 24'(limit_q);
  assign rem2  = {cnt1_q, 16'h0} - qmul2;
  assign t2_d  = (rem2 >= 24'(limit_q)) ? qa1_q + 16'd1 : qa1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      black2_q <= black1_q;
      t2_q     <= t2_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: first segment whose right stop is at or above t
  // --------------------------------------------------------------------------
  logic [SegW-1:0]  seg3_d;
  logic [16:0]      diff3;
  logic             black3_q;
  logic [SegW-1:0]  seg3_q;
  logic [DiffW-1:0] d3_q;

  always_comb begin
    seg3_d = SegW'(igc_pkg::SegCnt - 1);
    for (int i = igc_pkg::SegCnt - 2; i >= 0; i--) begin
      if ({1'b0, t2_q} <= igc_pkg::STOP_POS[i+1]) begin
        seg3_d = SegW'(i);
      end
    end
  end

  // t is at or above the left stop of the chosen segment, so this never wraps
  assign diff3 = {1'b0, t2_q} - igc_pkg::STOP_POS[seg3_d];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      black3_q <= black2_q;
      seg3_q   <= seg3_d;
      d3_q     <= diff3[DiffW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: approximate local fraction d * 2^16 / width (may be one low)
  // --------------------------------------------------------------------------
  logic [35:0]      prod4;
  logic             black4_q;
  logic [SegW-1:0]  seg4_q;
  logic [DiffW-1:0] d4_q;
  logic [16:0]      fa4_q;

  assign prod4 = 36'(d3_q) * 36'(igc_pkg::SEG_RECIP[seg3_q]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      black4_q <= black3_q;
      seg4_q   <= seg3_q;
      d4_q     <= d3_q;
      fa4_q    <= prod4[32:16];
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: fraction fix-up; zero-width segment takes the right stop
  // --------------------------------------------------------------------------
  logic [DiffW-1:0] width5;
  logic [29:0]      fmul5;
  logic [29:0]      rem5;
  logic [16:0]      f5_d;
  logic             black5_q;
  logic [SegW-1:0]  seg5_q;
  logic [16:0]      f5_q;

  assign width5 = igc_pkg::SEG_WIDTH[seg4_q];
  assign fmul5  = 30'(fa4_q) * 30'(width5);
  assign rem5   = {1'b0, d4_q, 16'h0} - fmul5;

  always_comb begin
    if (width5 == '0) begin
      f5_d = igc_pkg::OneQ16;
    end else if (rem5 >= 30'(width5)) begin
      f5_d = fa4_q + 17'd1;
    end else begin
      f5_d = fa4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      black5_q <= black4_q;
      seg5_q   <= seg4_q;
      f5_q     <= f5_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: blend channels between the two stops, round half-up
  // --------------------------------------------------------------------------
  logic [SegW-1:0] hi6;
  logic [16:0]     fc6;
  logic [25:0]     acc_r, acc_g, acc_b;
  logic [7:0]      red_q, green_q, blue_q;

  assign hi6 = seg5_q + 5'd1;
  assign fc6 = igc_pkg::OneQ16 - f5_q;

  assign acc_r = 26'(igc_pkg::STOP_R[seg5_q]) * 26'(fc6)
               + 26'(igc_pkg::STOP_R[hi6]) * 26'(f5_q) + igc_pkg::HalfQ16;
  assign acc_g = 26'(igc_pkg::STOP_G[seg5_q]) * 26'(fc6)
               + 26'(igc_pkg::STOP_G[hi6]) * 26'(f5_q) + igc_pkg::HalfQ16;
  assign acc_b = 26'(igc_pkg::STOP_B[seg5_q]) * 26'(fc6)
               + 26'(igc_pkg::STOP_B[hi6]) * 26'(f5_q) + igc_pkg::HalfQ16;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= black5_q ? 8'h00 : acc_r[23:16];
      green_q <= black5_q ? 8'h00 : acc_g[23:16];
      blue_q  <= black5_q ? 8'h00 : acc_b[23:16];
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule
